// ----- design/sl2rc_pkg.sv -----
// Shared types for the row completion block.
`timescale 1ns / 1ps
package sl2rc_pkg;
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

// ----- design/sl2rc_div.sv -----
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sl2rc_div
  import sl2rc_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output div_ctl_t     ctl,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [W:0]   r_r, r_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [W:0] sh, df;

  always_comb begin
    sh = {r_r[W-1:0], q_r[W-1]};
    df = sh - {1'b0, d_r};
    q_nxt = q_r; d_nxt = d_r; r_nxt = r_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = dividend; d_nxt = divisor; r_nxt = '0;
      cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (df[W]) begin
        r_nxt = sh; q_nxt = {q_r[W-2:0], 1'b0};
      end else begin
        r_nxt = df; q_nxt = {q_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; r_r <= r_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[W-1:0];
  assign ctl  = '{start: start, busy: busy_r};
endmodule

// ----- design/sl2rc_mac.sv -----
// Bit-serial multiply-subtract: y = acc - q * x, both pairs, one bit of q per cycle.
`timescale 1ns / 1ps
module sl2rc_mac #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] q,
  input  logic [W-1:0] x0,
  input  logic [W-1:0] x1,
  input  logic [W-1:0] acc0,
  input  logic [W-1:0] acc1,
  output logic         done,
  output logic [W-1:0] y0,
  output logic [W-1:0] y1
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt, x0_r, x0_nxt, x1_r, x1_nxt, a0_r, a0_nxt, a1_r, a1_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q_nxt = q_r; x0_nxt = x0_r; x1_nxt = x1_r; a0_nxt = a0_r; a1_nxt = a1_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = q; x0_nxt = x0; x1_nxt = x1; a0_nxt = acc0; a1_nxt = acc1;
      cnt_nxt = CW'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      // subtract shifted multiplicand where the quotient bit is set
      if (q_r[0]) begin
        a0_nxt = a0_r - x0_r; a1_nxt = a1_r - x1_r;
      end
      q_nxt = q_r >> 1;
      x0_nxt = x0_r << 1; x1_nxt = x1_r << 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; x0_r <= x0_nxt; x1_r <= x1_nxt; a0_r <= a0_nxt; a1_r <= a1_nxt;
  end

  assign done = done_r;
  assign y0 = a0_r;
  assign y1 = a1_r;
endmodule

// ----- design/sl2_row_completion_top.sv -----
// Top level of the SL2 row completion block.
`timescale 1ns / 1ps
// Completes a bottom row (c, d) to [[a, -b], [c, d]] with a*d + b*c equal to
// the last nonzero Euclidean remainder, all values wrapping at WIDTH bits.
// One row is processed at a time. Each Euclidean step passes through a test
// state, runs a bit-serial divider and then a bit-serial multiply-subtract.
// The result register frees the input once the result is taken.
module sl2_row_completion_top
  import sl2rc_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // lower_left[31:0], lower_right[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // top_left[31:0], top_right[63:32]
);
  localparam logic [2:0] S_IDLE = 3'd0, S_TEST = 3'd1, S_DIV = 3'd2,
                         S_MAC = 3'd3, S_OUT = 3'd4;
  localparam int W = WIDTH;

  logic [2:0] st_r, st_nxt;
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, s1_r, s1_nxt, t1_r, t1_nxt;
  logic [W-1:0] s2_r, s2_nxt, t2_r, t2_nxt, q_r, q_nxt, r_r, r_nxt;
  logic [63:0] od_r, od_nxt;
  logic ov_r, ov_nxt;
  logic mac_go_r;
  logic div_start, mac_start, div_done, mac_done;
  logic [W-1:0] ma, mb, qm, rm, y0, y1;
  logic [W-1:0] c_w, d_w;
  div_ctl_t dctl;

  function automatic logic [W-1:0] wrap32(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[W-1:0];
  endfunction

  function automatic logic [31:0] ext32(input logic [W-1:0] v);
    logic [63:0] e;
    e = {{(64-W){v[W-1]}}, v};
    return e[31:0];
  endfunction

  assign c_w = wrap32(in_tdata[31:0]);
  assign d_w = wrap32(in_tdata[63:32]);
  assign ma = a_r[W-1] ? -a_r : a_r;
  assign mb = b_r[W-1] ? -b_r : b_r;

  // launch the multiply-subtract in the first S_MAC cycle, once the quotient is latched
  assign mac_start = mac_go_r;

  sl2rc_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mb), .divisor(ma),
    .ctl(dctl), .done(div_done), .quot(qm), .rem(rm)
  );

  sl2rc_mac #(.W(W)) u_mac (
    .clk(clk), .rst_n(rst_n), .start(mac_start), .q(q_r), .x0(s1_r), .x1(t1_r),
    .acc0(s2_r), .acc1(t2_r), .done(mac_done), .y0(y0), .y1(y1)
  );

  assign in_tready = (st_r == S_IDLE) && !ov_r;

  always_comb begin
    st_nxt = st_r; a_nxt = a_r; b_nxt = b_r; s1_nxt = s1_r; t1_nxt = t1_r;
    s2_nxt = s2_r; t2_nxt = t2_r; q_nxt = q_r; r_nxt = r_r;
    od_nxt = od_r; ov_nxt = ov_r;
    div_start = 1'b0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          a_nxt = c_w; b_nxt = d_w;
          s1_nxt = W'(1); t1_nxt = '0; s2_nxt = '0; t2_nxt = W'(1);
          st_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (a_r == '0) begin
          st_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done && !dctl.busy) begin
          q_nxt = (a_r[W-1] != b_r[W-1]) ? -qm : qm;
          r_nxt = b_r[W-1] ? -rm : rm;
          st_nxt = S_MAC;
        end
      end
      S_MAC: begin
        // first cycle here launches the multiply-subtract with the latched quotient
        if (mac_done) begin
          s2_nxt = s1_r; t2_nxt = t1_r; s1_nxt = y0; t1_nxt = y1;
          b_nxt = a_r; a_nxt = r_r;
          st_nxt = S_TEST;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          od_nxt = {ext32(-s2_r), ext32(t2_r)};
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; mac_go_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
      mac_go_r <= (st_r == S_DIV) && (st_nxt == S_MAC);
    end
    a_r <= a_nxt; b_r <= b_nxt; s1_r <= s1_nxt; t1_r <= t1_nxt;
    s2_r <= s2_nxt; t2_r <= t2_nxt; q_r <= q_nxt; r_r <= r_nxt; od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule
